/* rtl/core/qple_pkg.sv */
// ----------------------------------------------------------------------------
// qple_pkg: shared types and constants of the quoted-printable line encoder
// Character codes, the per-word output plan passed from the front end to the
// back end, the configuration bundle and the hex digit helper.
// ----------------------------------------------------------------------------
package qple_pkg;

  // Character codes
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_DOT  = 8'd46;
  localparam logic [7:0] CH_EQ   = 8'd61;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  // Line limit reset value and floor
  localparam logic [7:0] MAX_LINE_RESET = 8'd75;
  localparam logic [7:0] LIMIT_FLOOR    = 8'd4;

  // Configuration register indexes
  localparam logic [7:0] REG_MAX_LINE  = 8'd0;
  localparam logic [7:0] REG_DOT_STUFF = 8'd1;

  // Most output bytes one input word can cause, and a slot index for them
  localparam int MAX_BYTES = 7;
  localparam int SLOT_W    = $clog2(MAX_BYTES);

  // Body of one input word's output
  typedef enum logic [1:0] {
    K_NONE,
    K_BREAK,
    K_PLAIN,
    K_ESC
  } kind_t;

  // Output plan of one input word
  typedef struct packed {
    logic [1:0] dots;      // held dots to send first: 0, 1 or 2
    kind_t      kind;      // body
    logic       soft_brk;  // soft break after the body
    logic [7:0] data;      // raw byte
  } plan_t;

  // Configuration registers
  typedef struct packed {
    logic [7:0] max_line;
    logic       dot_stuff;
  } cfg_t;

  // Uppercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'd48 + {4'd0, v};
    end else begin
      r = 8'd55 + {4'd0, v};
    end
    return r;
  endfunction

endpackage

/* rtl/core/quoted_printable_line_encoder.sv */
// ----------------------------------------------------------------------------
// quoted_printable_line_encoder: byte stream quoted-printable encoder
// Encodes raw message bytes with line breaks, soft breaks and dot stuffing.
// ----------------------------------------------------------------------------
// Usage:
//   s_* is the input stream, one raw byte per word; s_tlast marks the final
//   byte of a message and clears line state after it is encoded.
//   m_* is the output stream, one encoded character per word; m_tlast marks
//   the last character caused by one input word. A word that causes nothing
//   (a held dot, the LF of CR LF) produces no output word.
//   cfg_* writes max_line (index 0) and dot_stuff_enable (index 1); write it
//   only while the encoder is idle. cfg_ready is always high.
// Timing:
//   The front end takes one input word per cycle while the plan queue has
//   room. The back end sends one output character per cycle while m_tready
//   is high, so an input word's output time is set by its character count;
//   plain text without soft breaks runs at one word per cycle. After an input
//   word is accepted, its first character passes the queue write and then
//   the output register. When m_tready is low the output word holds, the
//   queue fills, and s_tready drops once QUEUE_DEPTH plans wait.
// Reset:
//   rst clears line state, empties the queue, drops m_tvalid and restores
//   max_line to 75 and dot stuffing to on.
// ----------------------------------------------------------------------------
module quoted_printable_line_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_data
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // last_of_item
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  qple_pkg::cfg_t  cfg;
  qple_pkg::plan_t plan_in;
  qple_pkg::plan_t plan_head;
  logic            q_push;
  logic            q_pop;
  logic            q_empty;
  logic            q_full;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_line  <= qple_pkg::MAX_LINE_RESET;
      cfg.dot_stuff <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == qple_pkg::REG_MAX_LINE) begin
        cfg.max_line <= cfg_data;
      end else if (cfg_index == qple_pkg::REG_DOT_STUFF) begin
        cfg.dot_stuff <= cfg_data[0];
      end
    end
  end

  qple_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .q_full   (q_full),
    .push     (q_push),
    .plan     (plan_in)
  );

  qple_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(qple_pkg::plan_t))
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (plan_in),
    .pop       (q_pop),
    .head      (plan_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  qple_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (plan_head),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

/* rtl/core/qple_queue.sv */
// ----------------------------------------------------------------------------
// qple_queue: small plan queue between front end and back end
// Register-based FIFO with a combinational head, so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module qple_queue #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] store [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head  = store[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == DEPTH_CNT);

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/qple_front.sv */
// ----------------------------------------------------------------------------
// qple_front: input side of the encoder
// Accepts one raw byte per cycle while the queue has room, tracks line
// position, held dot, pending CR, and turns each word into an output plan.
// ----------------------------------------------------------------------------
module qple_front (
  input  logic               clk,
  input  logic               rst,
  input  qple_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic               q_full,
  output logic               push,
  output qple_pkg::plan_t    plan
);

  logic [7:0] line_count;
  logic       dot_held;
  logic       after_cr;

  logic [7:0] line_count_next;
  logic       dot_held_next;
  logic       after_cr_next;

  logic       brk;
  logic       printable;
  logic [7:0] lim;
  logic [7:0] lc_start;
  logic [8:0] cnt;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && ((plan.dots != 2'd0) || (plan.kind != qple_pkg::K_NONE));

  // Classify the byte and work out the next line state
  always_comb begin
    brk = (in_byte == qple_pkg::CH_LF) || (in_byte == qple_pkg::CH_CR);
    printable = (in_byte >= qple_pkg::PRINT_LO) && (in_byte <= qple_pkg::PRINT_HI)
                && (in_byte != qple_pkg::CH_EQ);
    lim = (cfg.max_line < qple_pkg::LIMIT_FLOOR) ? qple_pkg::LIMIT_FLOOR : cfg.max_line;
    lc_start = (dot_held && !brk) ? 8'd1 : line_count;
    cnt = '0;

    plan.dots     = dot_held ? (brk ? 2'd2 : 2'd1) : 2'd0;
    plan.kind     = qple_pkg::K_NONE;
    plan.soft_brk = 1'b0;
    plan.data     = in_byte;

    line_count_next = lc_start;
    dot_held_next   = 1'b0;
    after_cr_next   = 1'b0;

    if (after_cr && (in_byte == qple_pkg::CH_LF)) begin
      // drop the LF of a CR LF pair
      line_count_next = lc_start;
    end else if (brk) begin
      plan.kind       = qple_pkg::K_BREAK;
      line_count_next = '0;
      after_cr_next   = (in_byte == qple_pkg::CH_CR);
    end else if ((lc_start == 8'd0) && (in_byte == qple_pkg::CH_DOT) && cfg.dot_stuff
                 && !in_last) begin
      dot_held_next = 1'b1;
    end else begin
      if (printable) begin
        plan.kind = qple_pkg::K_PLAIN;
        cnt = {1'b0, lc_start} + 9'd1;
      end else begin
        plan.kind = qple_pkg::K_ESC;
        cnt = {1'b0, lc_start} + 9'd3;
      end
      if (cnt >= {1'b0, lim}) begin
        plan.soft_brk   = 1'b1;
        line_count_next = '0;
      end else begin
        line_count_next = cnt[7:0];
      end
    end

    // end of message clears the line state
    if (in_last) begin
      line_count_next = '0;
      dot_held_next   = 1'b0;
      after_cr_next   = 1'b0;
    end
  end

  // Hold line state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      dot_held   <= 1'b0;
      after_cr   <= 1'b0;
    end else if (accept) begin
      line_count <= line_count_next;
      dot_held   <= dot_held_next;
      after_cr   <= after_cr_next;
    end
  end

endmodule

/* rtl/core/qple_back.sv */
// ----------------------------------------------------------------------------
// qple_back: output side of the encoder
// Expands the plan at the queue head into its byte sequence and sends one
// byte per cycle, while out_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module qple_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  qple_pkg::plan_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic [7:0]                  seq [0:qple_pkg::MAX_BYTES-1];
  logic [qple_pkg::SLOT_W-1:0] n;
  logic [qple_pkg::SLOT_W-1:0] slot;
  logic [7:0]                  cur_byte;
  logic                        cur_last;
  logic                        load;

  // Lay out the byte sequence of the head plan
  always_comb begin
    for (int i = 0; i < qple_pkg::MAX_BYTES; i++) begin
      seq[i] = qple_pkg::CH_EQ;
    end
    n = '0;
    if (head.dots != 2'd0) begin
      seq[n] = qple_pkg::CH_DOT;
      n = n + qple_pkg::SLOT_W'(1);
    end
    if (head.dots == 2'd2) begin
      seq[n] = qple_pkg::CH_DOT;
      n = n + qple_pkg::SLOT_W'(1);
    end
    unique case (head.kind)
      qple_pkg::K_BREAK: begin
        seq[n] = qple_pkg::CH_CR;
        seq[n + qple_pkg::SLOT_W'(1)] = qple_pkg::CH_LF;
        n = n + qple_pkg::SLOT_W'(2);
      end
      qple_pkg::K_PLAIN: begin
        seq[n] = head.data;
        n = n + qple_pkg::SLOT_W'(1);
      end
      qple_pkg::K_ESC: begin
        seq[n] = qple_pkg::CH_EQ;
        seq[n + qple_pkg::SLOT_W'(1)] = qple_pkg::hex_digit(head.data[7:4]);
        seq[n + qple_pkg::SLOT_W'(2)] = qple_pkg::hex_digit(head.data[3:0]);
        n = n + qple_pkg::SLOT_W'(3);
      end
      qple_pkg::K_NONE: begin
        n = n;
      end
    endcase
    if (head.soft_brk) begin
      seq[n] = qple_pkg::CH_EQ;
      seq[n + qple_pkg::SLOT_W'(1)] = qple_pkg::CH_CR;
      seq[n + qple_pkg::SLOT_W'(2)] = qple_pkg::CH_LF;
      n = n + qple_pkg::SLOT_W'(3);
    end
  end

  assign cur_byte = seq[slot];
  assign cur_last = (slot == n - qple_pkg::SLOT_W'(1));
  assign load     = !q_empty && (!out_valid || out_ready);
  assign pop      = load && cur_last;

  // Step through the sequence and hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= '0;
    end else begin
      if (!out_valid || out_ready) begin
        out_valid <= !q_empty;
      end
      if (load) begin
        out_byte <= cur_byte;
        out_last <= cur_last;
        slot     <= cur_last ? '0 : slot + qple_pkg::SLOT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/qple_checker.sv */
// ----------------------------------------------------------------------------
// qple_port_checks: port-level checks of the encoder
// Watches the output stream for stalls, reset, legal characters and CR LF.
// ----------------------------------------------------------------------------
module qple_port_checks (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // Nothing is sent straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Only printable characters, CR and LF leave the encoder
  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata >= qple_pkg::PRINT_LO) && (m_tdata <= qple_pkg::PRINT_HI))
                 || (m_tdata == qple_pkg::CH_CR) || (m_tdata == qple_pkg::CH_LF))
    else $error("illegal output character");

  // A taken CR is followed by LF as the next word
  a_cr_then_lf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && (m_tdata == qple_pkg::CH_CR) |=>
      m_tvalid && (m_tdata == qple_pkg::CH_LF))
    else $error("CR not followed by LF");

endmodule

bind quoted_printable_line_encoder qple_port_checks u_qple_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* bench/qple_checker.sv */
// ----------------------------------------------------------------------------
// qple_checker: output predictor and scoreboard for the QP line encoder
// Watches the config, input and output streams at the rising edge, encodes
// every accepted input word with its own copy of the line state and register
// values, and compares each output word against the oldest expected one.
// ----------------------------------------------------------------------------
module qple_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_data
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_byte
  input  logic       m_tlast,   // last_of_item
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         waiting
);

  localparam int MAX_PRINTED = 50;
  localparam logic [7:0] ASCII_0 = "0";
  localparam logic [7:0] ASCII_A = "A";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  // Expected encoded characters, oldest first
  enc_char_t  encoded_q[$];
  enc_char_t  want;

  // Shadow registers and line state
  logic [7:0] limit_reg;
  logic       stuff_reg;
  int         line_len;
  logic       dot_waiting;
  logic       cr_seen;

  int         mismatches;
  int         chars_seen;

  initial begin
    fail_count = 0;
    waiting    = 0;
    mismatches = 0;
    chars_seen = 0;
  end

  // Print one line per mismatch (up to a cap) and count it
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = ASCII_0 + {4'd0, n};
    end else begin
      c = ASCII_A + {4'd0, n} - 8'd10;
    end
    return c;
  endfunction

  // Encode one raw byte and queue the characters it produces
  task automatic encode_byte(input logic [7:0] b, input logic eod);
    logic [7:0] seq[$];
    int         limit;
    int         cnt;
    logic       brk;
    enc_char_t  e;
    limit = (limit_reg < qple_pkg::LIMIT_FLOOR) ? int'(qple_pkg::LIMIT_FLOOR)
                                                 : int'(limit_reg);
    brk   = (b == qple_pkg::CH_LF) || (b == qple_pkg::CH_CR);

    // Resolve a dot held at line start
    if (dot_waiting) begin
      dot_waiting = 1'b0;
      seq.push_back(qple_pkg::CH_DOT);
      if (brk) begin
        seq.push_back(qple_pkg::CH_DOT);
      end else begin
        line_len = 1;
      end
    end

    if (cr_seen && b == qple_pkg::CH_LF) begin
      // LF of CR LF: already sent
      cr_seen = 1'b0;
    end else if (brk) begin
      seq.push_back(qple_pkg::CH_CR);
      seq.push_back(qple_pkg::CH_LF);
      line_len = 0;
      cr_seen  = (b == qple_pkg::CH_CR);
    end else begin
      cr_seen = 1'b0;
      if (line_len == 0 && b == qple_pkg::CH_DOT && stuff_reg && !eod) begin
        dot_waiting = 1'b1;
      end else begin
        cnt = line_len;
        if (b >= qple_pkg::PRINT_LO && b <= qple_pkg::PRINT_HI && b != qple_pkg::CH_EQ) begin
          seq.push_back(b);
          cnt += 1;
        end else begin
          seq.push_back(qple_pkg::CH_EQ);
          seq.push_back(nibble_char(b[7:4]));
          seq.push_back(nibble_char(b[3:0]));
          cnt += 3;
        end
        // Soft break once the line is full
        if (cnt >= limit) begin
          seq.push_back(qple_pkg::CH_EQ);
          seq.push_back(qple_pkg::CH_CR);
          seq.push_back(qple_pkg::CH_LF);
          cnt = 0;
        end
        line_len = cnt & 8'hFF;
      end
    end

    // End of message clears the line state
    if (eod) begin
      line_len    = 0;
      dot_waiting = 1'b0;
      cr_seen     = 1'b0;
    end

    foreach (seq[i]) begin
      e.ch   = seq[i];
      e.last = (i == seq.size() - 1);
      encoded_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      encoded_q.delete();
      limit_reg   = qple_pkg::MAX_LINE_RESET;
      stuff_reg   = 1'b1;
      line_len    = 0;
      dot_waiting = 1'b0;
      cr_seen     = 1'b0;
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          qple_pkg::REG_MAX_LINE: begin
            limit_reg = cfg_data;
          end
          qple_pkg::REG_DOT_STUFF: begin
            stuff_reg = cfg_data[0];
          end
          default: begin
          end
        endcase
      end

      if (s_tvalid && s_tready) begin
        encode_byte(s_tdata, s_tlast);
      end

      // Compare each output word against the oldest expectation
      if (m_tvalid && m_tready) begin
        chars_seen++;
        if (encoded_q.size() == 0) begin
          report_mismatch($sformatf("char %0d: unexpected word %02h last %0b",
                                    chars_seen, m_tdata, m_tlast));
        end else begin
          want = encoded_q.pop_front();
          if (m_tdata !== want.ch) begin
            report_mismatch($sformatf("char %0d: out_byte %02h, expected %02h",
                                      chars_seen, m_tdata, want.ch));
          end
          if (m_tlast !== want.last) begin
            report_mismatch($sformatf("char %0d: last_of_item %0b, expected %0b",
                                      chars_seen, m_tlast, want.last));
          end
        end
      end
    end
    fail_count <= mismatches;
    waiting    <= encoded_q.size();
  end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the quoted-printable line encoder
// Drives a directed set of bytes covering escapes, line breaks and dot
// stuffing, then phases of random text under several register settings and
// idle patterns, including a long output stall. A checker beside the encoder
// predicts and compares every output word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         RX_HOLD_CYCLES = 300;
  localparam int         DRAIN_CYCLES   = 10;
  localparam int         PHASE_WORDS    = 60;
  localparam logic [7:0] REG_UNUSED     = 8'hFF;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'd0;   // [7:0] data_byte
  logic       s_tlast   = 1'b0;   // end_of_data
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;            // [7:0] out_byte
  logic       m_tlast;            // last_of_item
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'd0;
  logic [7:0] cfg_data  = 8'd0;

  int fail_count;
  int waiting;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int rx_hold_left   = 0;
  int idle_cycles    = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  quoted_printable_line_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qple_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  // Output side: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      m_tready     <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      rx_hold_left <= RX_HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one input word, with random idle cycles in front; call at negedge
  task automatic send_word(input logic [7:0] b, input logic eod);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eod;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Write one register; call at negedge, caller drops cfg_valid afterwards
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Drop input valid and wait until every expected character has arrived
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Text-like byte: mostly printable, with breaks, dots after breaks, noise
  function automatic logic [7:0] pick_text_byte(input logic [7:0] prev);
    int         r;
    logic [7:0] b;
    r = $urandom_range(99);
    if ((prev == qple_pkg::CH_LF || prev == qple_pkg::CH_CR) && r < 35) begin
      b = qple_pkg::CH_DOT;
    end else if (r < 50) begin
      b = 8'($urandom_range(qple_pkg::PRINT_HI, qple_pkg::PRINT_LO));
    end else if (r < 64) begin
      b = 8'($urandom_range(255, 0));
    end else if (r < 72) begin
      b = qple_pkg::CH_LF;
    end else if (r < 79) begin
      b = qple_pkg::CH_CR;
    end else if (r < 86) begin
      b = qple_pkg::CH_DOT;
    end else if (r < 90) begin
      b = qple_pkg::CH_EQ;
    end else begin
      b = 8'($urandom_range(qple_pkg::PRINT_HI, qple_pkg::PRINT_LO));
    end
    return b;
  endfunction

  // One phase: set registers while idle, then a run of random text
  task automatic run_phase(input logic [7:0] limit, input logic stuff,
                           input int send_pct, input int recv_pct,
                           input bit squeeze, input bit poke_unused);
    logic [7:0] prev;
    logic [7:0] b;
    settle();
    write_reg(qple_pkg::REG_MAX_LINE, limit);
    write_reg(qple_pkg::REG_DOT_STUFF, {7'd0, stuff});
    if (poke_unused) begin
      write_reg(REG_UNUSED, 8'hFF);
    end
    cfg_valid      <= 1'b0;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) begin
      hold_requests++;
    end
    prev = qple_pkg::CH_LF;
    for (int k = 0; k < PHASE_WORDS; k++) begin
      b = pick_text_byte(prev);
      send_word(b, $urandom_range(99) < 4);
      prev = b;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: escape extremes, printable edges, breaks, dot stuffing
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(qple_pkg::PRINT_LO, 1'b0);
    send_word(qple_pkg::PRINT_HI, 1'b0);
    send_word(8'd60, 1'b0);
    send_word(qple_pkg::CH_EQ, 1'b0);
    send_word(8'd62, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h09, 1'b0);
    send_word(8'hA5, 1'b0);
    send_word(qple_pkg::CH_LF, 1'b0);
    // dot before LF, dot before CR LF
    send_word(qple_pkg::CH_DOT, 1'b0);
    send_word(qple_pkg::CH_LF, 1'b0);
    send_word(qple_pkg::CH_DOT, 1'b0);
    send_word(qple_pkg::CH_CR, 1'b0);
    send_word(qple_pkg::CH_LF, 1'b0);
    // lone CR must not swallow the next byte
    send_word(qple_pkg::CH_CR, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(qple_pkg::CH_CR, 1'b0);
    // held dot released by ordinary text
    send_word(qple_pkg::CH_DOT, 1'b0);
    send_word(8'h78, 1'b0);
    send_word(qple_pkg::CH_LF, 1'b0);
    // dot on the final byte, then a dot before a final CR
    send_word(qple_pkg::CH_DOT, 1'b1);
    send_word(qple_pkg::CH_DOT, 1'b0);
    send_word(qple_pkg::CH_CR, 1'b1);
    // leave a dot held while stuffing gets switched off
    send_word(qple_pkg::CH_DOT, 1'b0);

    // Random phases over register settings and idle patterns
    run_phase(8'd255, 1'b0, 0, 0, 1'b1, 1'b0);
    run_phase(8'd4, 1'b1, 69, 0, 1'b0, 1'b0);
    run_phase(8'd0, 1'b1, 0, 69, 1'b0, 1'b1);
    run_phase(8'd10, 1'b0, 27, 27, 1'b0, 1'b0);
    run_phase(8'd5, 1'b1, 0, 0, 1'b0, 1'b0);
    run_phase(8'd76, 1'b1, 27, 27, 1'b0, 1'b0);
    settle();

    if (fail_count == 0 && waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (waiting != 0) begin
        $display("%0d expected characters never arrived", waiting);
      end
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
